### rtl/core/ils_pkg.sv
// ============================================================================
// ils_pkg - shared types and constants for the indexed list store
// Capacity, word width, opcode and status codes, and the command and status
// structs that pass between the controller and the datapath.
// ============================================================================
package ils_pkg;

    // Storage geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Field widths fixed by the interface
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    // Entry count must hold CAPACITY itself
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    // Width used when comparing a position against the count
    localparam int CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_DELETE     = 3'd2,
        OP_SEARCH_ANY = 3'd3,
        OP_SEARCH_DUP = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_BAD_POS = 2'd1,
        STS_FULL    = 2'd2
    } t_status;

    // What the datapath does to the entry cells
    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_APPEND = 2'd1,
        WR_INSERT = 2'd2,
        WR_DELETE = 2'd3
    } t_write;

    // Which search result goes to the found flag
    typedef enum logic [1:0] {
        SR_NONE = 2'd0,
        SR_ANY  = 2'd1,
        SR_DUP  = 2'd2
    } t_search;

    typedef struct packed {
        logic    exec;
        t_write  wr;
        t_search srch;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic ins_pos_ok;
        logic del_pos_ok;
    } t_dp_stat;

endpackage

### rtl/core/ils_ctrl.sv
// ============================================================================
// ils_ctrl - controller for the indexed list store
// Runs the handshake on both channels, decodes the opcode against the
// datapath flags and issues one command per accepted request.
// ============================================================================
module ils_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ils_pkg::OPCODE_W-1:0]       i_opcode,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  ils_pkg::t_dp_stat                  i_stat,
    output ils_pkg::t_dp_cmd                   o_cmd
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_HOLD  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Take a new request whenever the result register is free or draining
    assign o_in_ready  = (r_state == ST_EMPTY) || i_out_ready;
    assign o_out_valid = (r_state == ST_HOLD);
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (w_accept) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_out_ready && !w_accept) n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // Opcode decode: position is checked before fullness on insert
    always_comb begin
        o_cmd.exec   = w_accept;
        o_cmd.wr     = ils_pkg::WR_NONE;
        o_cmd.srch   = ils_pkg::SR_NONE;
        o_cmd.status = ils_pkg::STS_OK;
        unique case (ils_pkg::t_opcode'(i_opcode))
            ils_pkg::OP_APPEND: begin
                if (i_stat.full) o_cmd.status = ils_pkg::STS_FULL;
                else             o_cmd.wr     = ils_pkg::WR_APPEND;
            end
            ils_pkg::OP_INSERT: begin
                if (!i_stat.ins_pos_ok) o_cmd.status = ils_pkg::STS_BAD_POS;
                else if (i_stat.full)   o_cmd.status = ils_pkg::STS_FULL;
                else                    o_cmd.wr     = ils_pkg::WR_INSERT;
            end
            ils_pkg::OP_DELETE: begin
                if (!i_stat.del_pos_ok) o_cmd.status = ils_pkg::STS_BAD_POS;
                else                    o_cmd.wr     = ils_pkg::WR_DELETE;
            end
            ils_pkg::OP_SEARCH_ANY: o_cmd.srch = ils_pkg::SR_ANY;
            ils_pkg::OP_SEARCH_DUP: o_cmd.srch = ils_pkg::SR_DUP;
            // unused opcodes write nothing and report status ok
            default: ;
        endcase
    end

endmodule

### rtl/core/ils_datapath.sv
// ============================================================================
// ils_datapath - entry cells, fill count and result register
// Each cell loads the new word, its lower or upper neighbor, or holds; all
// cells compare against the search word in parallel.
// ============================================================================
module ils_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ils_pkg::t_dp_cmd                   i_cmd,
    input  logic [ils_pkg::VALUE_W-1:0]        i_value,
    input  logic [ils_pkg::POS_W-1:0]          i_position,
    output ils_pkg::t_dp_stat                  o_stat,
    output logic [ils_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_found,
    output logic [ils_pkg::COUNT_W-1:0]        o_entry_count
);

    logic [ils_pkg::DATA_WIDTH-1:0] r_entries [ils_pkg::CAPACITY];
    logic [ils_pkg::COUNT_W-1:0]    r_fill;
    logic [ils_pkg::COUNT_W-1:0]    n_fill;
    ils_pkg::t_status               r_out_status;
    logic                           r_out_found;
    logic [ils_pkg::COUNT_W-1:0]    r_out_count;

    logic [ils_pkg::DATA_WIDTH-1:0] w_word;
    logic [ils_pkg::CMP_W-1:0]      w_pos;
    logic [ils_pkg::CMP_W-1:0]      w_fill;
    logic [ils_pkg::CAPACITY-1:0]   w_match;
    logic                           w_any;
    logic                           w_dup;
    logic                           w_found;

    assign w_word = i_value[ils_pkg::DATA_WIDTH-1:0];
    assign w_pos  = ils_pkg::CMP_W'(i_position);
    assign w_fill = ils_pkg::CMP_W'(r_fill);

    // Flags for the controller
    assign o_stat.full       = (r_fill == ils_pkg::COUNT_W'(ils_pkg::CAPACITY));
    assign o_stat.ins_pos_ok = (w_pos <= w_fill);
    assign o_stat.del_pos_ok = (w_pos < w_fill);

    // Entry cells
    genvar g;
    generate
        for (g = 0; g < ils_pkg::CAPACITY; g++) begin : g_cell
            localparam logic [ils_pkg::CMP_W-1:0] IDX = ils_pkg::CMP_W'(g);
            logic [ils_pkg::DATA_WIDTH-1:0] w_lower;
            logic [ils_pkg::DATA_WIDTH-1:0] w_upper;

            if (g == 0) begin : g_first
                assign w_lower = r_entries[g];
            end else begin : g_rest
                assign w_lower = r_entries[g-1];
            end
            if (g == ils_pkg::CAPACITY - 1) begin : g_last
                assign w_upper = r_entries[g];
            end else begin : g_inner
                assign w_upper = r_entries[g+1];
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    case (i_cmd.wr)
                        ils_pkg::WR_APPEND: begin
                            if (IDX == w_fill) r_entries[g] <= w_word;
                        end
                        ils_pkg::WR_INSERT: begin
                            if (IDX == w_pos)     r_entries[g] <= w_word;
                            else if (IDX > w_pos) r_entries[g] <= w_lower;
                        end
                        ils_pkg::WR_DELETE: begin
                            if (IDX >= w_pos) r_entries[g] <= w_upper;
                        end
                        default: ;
                    endcase
                end
            end

            // only valid entries take part in a search
            assign w_match[g] = (IDX < w_fill) && (r_entries[g] == w_word);
        end
    endgenerate

    // At least one and at least two hits
    assign w_any = |w_match;
    assign w_dup = |(w_match & (w_match - ils_pkg::CAPACITY'(1)));

    always_comb begin
        case (i_cmd.srch)
            ils_pkg::SR_ANY: w_found = w_any;
            ils_pkg::SR_DUP: w_found = w_dup;
            default:         w_found = 1'b0;
        endcase
    end

    // Fill count update
    always_comb begin
        case (i_cmd.wr)
            ils_pkg::WR_APPEND,
            ils_pkg::WR_INSERT: n_fill = r_fill + ils_pkg::COUNT_W'(1);
            ils_pkg::WR_DELETE: n_fill = r_fill - ils_pkg::COUNT_W'(1);
            default:            n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            r_fill <= n_fill;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= i_cmd.status;
            r_out_found  <= w_found;
            r_out_count  <= n_fill;
        end
    end

    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_entry_count = r_out_count;

endmodule

### rtl/core/indexed_list_store.sv
// ============================================================================
// indexed_list_store - fixed-capacity ordered list of data words
// Append, insert-at, delete-at and two searches over a register-cell store.
// ============================================================================
// Usage:
//   Requests arrive on i_in_valid / o_in_ready with i_opcode, i_value and
//   i_position; each request yields exactly one result on o_out_valid /
//   i_out_ready with o_status, o_found and o_entry_count.
//   The result of an accepted request is registered and is valid in the
//   cycle after acceptance. Throughput is one request per cycle while the
//   receiver takes each result, set by the update of the cell array (every
//   cell shifts or compares in parallel) and the one result register.
//   When the receiver stalls, the result is held and a new request is taken
//   only in the cycle the held result is taken, so at most one result waits.
//   Reset clears the entry count and drops any held result; the cells
//   themselves are not cleared and are never read beyond the count.
//   A full store drops appends and well-placed inserts with status full; a bad
//   position wins and is reported with status invalid position and changes nothing.
// ============================================================================
module indexed_list_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ils_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [ils_pkg::VALUE_W-1:0]        i_value,
    input  logic [ils_pkg::POS_W-1:0]          i_position,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ils_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_found,
    output logic [ils_pkg::COUNT_W-1:0]        o_entry_count
);

    ils_pkg::t_dp_cmd  w_cmd;
    ils_pkg::t_dp_stat w_stat;

    ils_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ils_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_stat        (w_stat),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_entry_count (o_entry_count)
    );

`ifndef SYNTHESIS
    // count never runs past capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= ils_pkg::COUNT_W'(ils_pkg::CAPACITY)))
        else $error("entry count above capacity");

    // an accepted request always shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request produced no result");

    // searches never fail and never change the count
    a_search_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && o_out_valid &&
         (i_opcode == ils_pkg::OP_SEARCH_ANY || i_opcode == ils_pkg::OP_SEARCH_DUP))
        |=> (o_status == ils_pkg::STS_OK) && (o_entry_count == $past(o_entry_count)))
        else $error("search changed state or reported an error");

    // found is only raised by a search
    a_found_search_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
         i_opcode != ils_pkg::OP_SEARCH_ANY && i_opcode != ils_pkg::OP_SEARCH_DUP)
        |=> !o_found)
        else $error("found raised by a non-search request");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench for indexed_list_store
// Drives append, insert, delete, search and unused-opcode requests through
// the valid/ready input, mirrors the list in the bench to predict each
// result, and checks every result against the oldest prediction while both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 370;
    localparam int BURST_LEN       = 40;
    localparam int LONG_HOLD       = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int POOL_SIZE       = 6;
    localparam int POS_TOP         = (1 << ils_pkg::POS_W) - 1;
    localparam logic [ils_pkg::OPCODE_W-1:0] OPC_UNUSED_TOP = '1;

    typedef struct packed {
        logic [ils_pkg::OPCODE_W-1:0] opc;
        logic [ils_pkg::VALUE_W-1:0]  val;
        logic [ils_pkg::POS_W-1:0]    pos;
    } t_list_req;

    typedef struct packed {
        ils_pkg::t_status             status;
        logic                         found;
        logic [ils_pkg::COUNT_W-1:0]  count;
    } t_list_rsp;

    // DUT ports
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic [ils_pkg::OPCODE_W-1:0]  i_opcode      = '0;
    logic [ils_pkg::VALUE_W-1:0]   i_value       = '0;
    logic [ils_pkg::POS_W-1:0]     i_position    = '0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic [ils_pkg::STATUS_W-1:0]  o_status;
    logic                          o_found;
    logic [ils_pkg::COUNT_W-1:0]   o_entry_count;

    // Request stream and predicted results
    t_list_req pending_requests[$];
    t_list_rsp pending_results[$];
    int        n_issued   = 0;
    int        n_accepted = 0;
    int        n_errors   = 0;
    bit        req_taken  = 1'b0;
    int        idle_cycles = 0;

    // Idling knobs, set per phase
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int stall_order   = 0;
    int stall_served  = 0;
    int hold_left     = 0;

    // Mirror of the list contents
    logic [ils_pkg::DATA_WIDTH-1:0] mirror_words[ils_pkg::CAPACITY];
    int                             mirror_fill = 0;

    logic [ils_pkg::VALUE_W-1:0] value_pool[POOL_SIZE];

    indexed_list_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one accepted request to the mirror and queue its result
    task automatic apply_request(input t_list_req rq);
        t_list_rsp                      rsp;
        logic [ils_pkg::DATA_WIDTH-1:0] word;
        int                             hits;
        int                             i;
        int                             at;
        word       = rq.val[ils_pkg::DATA_WIDTH-1:0];
        at         = int'(rq.pos);
        rsp.status = ils_pkg::STS_OK;
        rsp.found  = 1'b0;
        hits       = 0;
        for (i = 0; i < mirror_fill; i++) begin
            if (mirror_words[i] == word) hits++;
        end
        case (rq.opc)
            ils_pkg::OP_APPEND: begin
                if (mirror_fill >= ils_pkg::CAPACITY) begin
                    rsp.status = ils_pkg::STS_FULL;
                end else begin
                    mirror_words[mirror_fill] = word;
                    mirror_fill++;
                end
            end
            ils_pkg::OP_INSERT: begin
                // position check wins over the full check
                if (at > mirror_fill) begin
                    rsp.status = ils_pkg::STS_BAD_POS;
                end else if (mirror_fill >= ils_pkg::CAPACITY) begin
                    rsp.status = ils_pkg::STS_FULL;
                end else begin
                    for (i = mirror_fill; i > at; i--) mirror_words[i] = mirror_words[i-1];
                    mirror_words[at] = word;
                    mirror_fill++;
                end
            end
            ils_pkg::OP_DELETE: begin
                if (at >= mirror_fill) begin
                    rsp.status = ils_pkg::STS_BAD_POS;
                end else begin
                    for (i = at; i + 1 < mirror_fill; i++) mirror_words[i] = mirror_words[i+1];
                    mirror_fill--;
                end
            end
            ils_pkg::OP_SEARCH_ANY: rsp.found = (hits >= 1);
            ils_pkg::OP_SEARCH_DUP: rsp.found = (hits >= 2);
            default: ;
        endcase
        rsp.count = ils_pkg::COUNT_W'(mirror_fill);
        pending_results.push_back(rsp);
    endtask

    task automatic queue_request(input logic [ils_pkg::OPCODE_W-1:0] opc,
                                 input logic [ils_pkg::VALUE_W-1:0] val,
                                 input logic [ils_pkg::POS_W-1:0] pos);
        t_list_req rq;
        rq.opc = opc;
        rq.val = val;
        rq.pos = pos;
        pending_requests.push_back(rq);
        n_issued++;
    endtask

    // Random request, biased toward filling or toward draining the list
    function automatic t_list_req random_request(input bit grow);
        t_list_req rq;
        int        pick;
        pick = $urandom_range(0, 99);
        if (grow) begin
            rq.opc = pick < 30 ? ils_pkg::OP_APPEND :
                     pick < 55 ? ils_pkg::OP_INSERT :
                     pick < 65 ? ils_pkg::OP_DELETE :
                     pick < 80 ? ils_pkg::OP_SEARCH_ANY :
                     pick < 95 ? ils_pkg::OP_SEARCH_DUP : OPC_UNUSED_TOP;
        end else begin
            rq.opc = pick < 10 ? ils_pkg::OP_APPEND :
                     pick < 20 ? ils_pkg::OP_INSERT :
                     pick < 60 ? ils_pkg::OP_DELETE :
                     pick < 78 ? ils_pkg::OP_SEARCH_ANY :
                     pick < 95 ? ils_pkg::OP_SEARCH_DUP : OPC_UNUSED_TOP;
        end
        if (rq.opc == OPC_UNUSED_TOP)
            rq.opc = ils_pkg::OPCODE_W'($urandom_range(int'(ils_pkg::OP_SEARCH_DUP) + 1,
                                                       int'(OPC_UNUSED_TOP)));
        pick = $urandom_range(0, 99);
        rq.pos = pick < 60 ? ils_pkg::POS_W'($urandom_range(0, 8)) :
                 pick < 90 ? ils_pkg::POS_W'($urandom_range(0, ils_pkg::CAPACITY)) :
                             ils_pkg::POS_W'($urandom_range(0, POS_TOP));
        // mostly pool values so searches hit and duplicates build up
        rq.val = ($urandom_range(0, 99) < 65) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : ils_pkg::VALUE_W'($urandom);
        return rq;
    endfunction

    // Poll on the falling edge until every request is back
    task automatic wait_all_done();
        while (!(n_accepted == n_issued && pending_results.size() == 0)) @(negedge i_clk);
    endtask

    // Request driver
    always @(negedge i_clk) begin
        t_list_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
                nxt = pending_requests.pop_front();
                i_opcode   <= nxt.opc;
                i_value    <= nxt.val;
                i_position <= nxt.pos;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (stall_order != stall_served) begin
            stall_served = stall_order;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    // Monitor: check results, predict accepted requests, watchdog
    always @(posedge i_clk) begin
        t_list_rsp want;
        bit        moved;
        if (!i_rst_n) begin
            req_taken   = 1'b0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: expected no result, got status %0d found %0d count %0d",
                             $time, o_status, o_found, o_entry_count);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_found !== want.found ||
                        o_entry_count !== want.count) begin
                        n_errors++;
                        $display("%0t: expected status %0d found %0d count %0d, got %0d %0d %0d",
                                 $time, want.status, want.found, want.count,
                                 o_status, o_found, o_entry_count);
                    end
                end
            end
            req_taken = i_in_valid && o_in_ready;
            if (req_taken) begin
                moved = 1'b1;
                apply_request('{opc: i_opcode, val: i_value, pos: i_position});
                n_accepted++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int ph;
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-store corners, ends of every field, full-store corners
        queue_request(ils_pkg::OP_DELETE, '0, '0);                  // delete from empty
        queue_request(ils_pkg::OP_SEARCH_ANY, '0, '0);              // search empty
        queue_request(ils_pkg::OP_INSERT, 32'h1234_5678, 5'd1);     // insert past the end
        queue_request(ils_pkg::OP_INSERT, '1, '0);
        queue_request(ils_pkg::OP_APPEND, '0, '0);
        queue_request(ils_pkg::OP_APPEND, '0, '0);
        queue_request(ils_pkg::OP_SEARCH_DUP, '0, '0);
        queue_request(ils_pkg::OP_SEARCH_DUP, '1, '0);
        queue_request(ils_pkg::OP_INSERT, 32'h5A5A_A5A5, 5'd3);     // insert at the end
        queue_request(ils_pkg::OP_DELETE, '0, ils_pkg::POS_W'(POS_TOP));
        queue_request(OPC_UNUSED_TOP, '1, ils_pkg::POS_W'(POS_TOP));
        for (k = 0; k < ils_pkg::CAPACITY - 4; k++)
            queue_request(ils_pkg::OP_APPEND, ils_pkg::VALUE_W'(k + 1), '0);
        queue_request(ils_pkg::OP_APPEND, 32'hDEAD_BEEF, '0);       // append when full
        queue_request(ils_pkg::OP_INSERT, 32'hDEAD_BEEF, ils_pkg::POS_W'(ils_pkg::CAPACITY));
        queue_request(ils_pkg::OP_INSERT, 32'hDEAD_BEEF,
                      ils_pkg::POS_W'(ils_pkg::CAPACITY + 1));
        queue_request(ils_pkg::OP_DELETE, '0, ils_pkg::POS_W'(ils_pkg::CAPACITY - 1));
        queue_request(ils_pkg::OP_DELETE, '0, '0);
        wait_all_done();

        // Random phases: no random idling, sender idle, receiver stalling, both
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            value_pool[0] = '0;
            value_pool[1] = '1;
            for (k = 2; k < POOL_SIZE; k++) value_pool[k] = ils_pkg::VALUE_W'($urandom);
            // long receiver hold-off while requests keep coming
            if (ph == 0 || ph == 2) stall_order++;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                pending_requests.push_back(random_request(((k / BURST_LEN) % 2) == 0));
                n_issued++;
            end
            // sender pauses until every result is back
            wait_all_done();
        end

        repeat (4) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ils_pkg.sv
rtl/core/ils_ctrl.sv
rtl/core/ils_datapath.sv
rtl/core/indexed_list_store.sv
tb/sv/tb_top.sv
